// File: rtl/ipdd_pkg.sv
package ipdd_pkg;

    localparam int DEF_FRAME_BITS = 32;
    localparam int WORD_BITS      = 32;
    localparam int TICK_W         = 16;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_W    = $clog2(QUEUE_DEPTH);
    localparam int OUT_TDATA_W    = 72;

    localparam logic [TICK_W-1:0] ZERO_LOW_RST        = 16'd100;
    localparam logic [TICK_W-1:0] ZERO_ONE_SPLIT_RST  = 16'd350;
    localparam logic [TICK_W-1:0] ONE_START_SPLIT_RST = 16'd500;
    localparam logic [TICK_W-1:0] START_HIGH_RST      = 16'd1500;

    typedef enum logic [1:0] {
        REG_ZERO_LOW        = 2'd0,
        REG_ZERO_ONE_SPLIT  = 2'd1,
        REG_ONE_START_SPLIT = 2'd2,
        REG_START_HIGH      = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        KIND_ZERO  = 2'd0,
        KIND_ONE   = 2'd1,
        KIND_START = 2'd2,
        KIND_JUNK  = 2'd3
    } t_kind;

    typedef struct packed {
        logic [7:0]           good_data;
        logic [7:0]           good_command;
        logic                 command_ok;
        logic [7:0]           data_byte;
        logic [7:0]           command_byte;
        logic [WORD_BITS-1:0] frame_word;
    } t_result;

endpackage

// File: rtl/ipdd_classifier.sv
module ipdd_classifier import ipdd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_addr,
    input  logic [TICK_W-1:0] i_cfg_data,
    input  logic [TICK_W-1:0] i_interval,
    output t_kind             o_kind
);

    logic [TICK_W-1:0] r_zero_low;
    logic [TICK_W-1:0] r_zero_one_split;
    logic [TICK_W-1:0] r_one_start_split;
    logic [TICK_W-1:0] r_start_high;
    logic              is_zero;
    logic              is_one;
    logic              is_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_low        <= ZERO_LOW_RST;
            r_zero_one_split  <= ZERO_ONE_SPLIT_RST;
            r_one_start_split <= ONE_START_SPLIT_RST;
            r_start_high      <= START_HIGH_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_ZERO_LOW:        r_zero_low        <= i_cfg_data;
                REG_ZERO_ONE_SPLIT:  r_zero_one_split  <= i_cfg_data;
                REG_ONE_START_SPLIT: r_one_start_split <= i_cfg_data;
                REG_START_HIGH:      r_start_high      <= i_cfg_data;
                default:             ;
            endcase
        end
    end

    assign is_zero  = (i_interval > r_zero_low)        && (i_interval < r_zero_one_split);
    assign is_one   = (i_interval > r_zero_one_split)  && (i_interval < r_one_start_split);
    assign is_start = (i_interval > r_one_start_split) && (i_interval < r_start_high);

    // start wins over one, one over zero when thresholds overlap
    always_comb begin
        if (is_start)     o_kind = KIND_START;
        else if (is_one)  o_kind = KIND_ONE;
        else if (is_zero) o_kind = KIND_ZERO;
        else              o_kind = KIND_JUNK;
    end

endmodule

// File: rtl/ipdd_queue.sv
module ipdd_queue import ipdd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_kind i_kind,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_kind o_kind
);

    t_kind                  r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wptr;
    logic [QUEUE_PTR_W-1:0] r_rptr;
    logic [QUEUE_PTR_W:0]   r_count;
    logic                   do_push;
    logic                   do_pop;

    assign o_full  = (r_count == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_kind  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wptr <= r_wptr + 1'b1;
            if (do_pop)  r_rptr <= r_rptr + 1'b1;
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: rtl/ipdd_assembler.sv
module ipdd_assembler import ipdd_pkg::*; #(
    parameter int FRAME_BITS = DEF_FRAME_BITS
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_kind   i_kind,
    output logic    o_pop,
    output logic    o_res_valid,
    input  logic    i_res_ready,
    output t_result o_result
);

    localparam int CNT_W = $clog2(FRAME_BITS + 1);

    logic [WORD_BITS-1:0] r_word;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_in_frame;
    logic [7:0]           r_good_cmd;
    logic [7:0]           r_good_data;
    logic                 r_res_valid;
    t_result              r_result;

    logic [WORD_BITS-1:0] n_word;
    logic [CNT_W-1:0]     n_cnt;
    logic                 take_bit;
    logic                 frame_done;
    logic [7:0]           cmd;
    logic [7:0]           inv;
    logic [7:0]           dat;
    logic                 ok;

    // an item is consumed whenever the output slot is free or being drained
    assign o_pop       = i_valid && (!r_res_valid || i_res_ready);
    assign take_bit    = o_pop && r_in_frame && (i_kind == KIND_ZERO || i_kind == KIND_ONE);
    assign n_cnt       = r_cnt + 1'b1;
    assign frame_done  = take_bit && (n_cnt == CNT_W'(FRAME_BITS));

    always_comb begin
        n_word = r_word;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (32'(r_cnt) == i) n_word[i] = (i_kind == KIND_ONE);
        end
    end

    assign cmd = n_word[31:24];
    assign inv = n_word[23:16];
    assign dat = n_word[15:8];
    assign ok  = (inv == ~cmd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word      <= '0;
            r_cnt       <= '0;
            r_in_frame  <= 1'b0;
            r_good_cmd  <= '0;
            r_good_data <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (frame_done)       r_res_valid <= 1'b1;
            else if (i_res_ready) r_res_valid <= 1'b0;
            if (o_pop && i_kind == KIND_START) begin
                r_word     <= '0;
                r_cnt      <= '0;
                r_in_frame <= 1'b1;
            end else if (frame_done) begin
                r_word      <= n_word;
                r_cnt       <= '0;
                r_in_frame  <= 1'b0;
                if (ok) begin
                    r_good_cmd  <= cmd;
                    r_good_data <= dat;
                end
            end else if (take_bit) begin
                r_word <= n_word;
                r_cnt  <= n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (frame_done) begin
            r_result.frame_word   <= n_word;
            r_result.command_byte <= cmd;
            r_result.data_byte    <= dat;
            r_result.command_ok   <= ok;
            r_result.good_command <= ok ? cmd : r_good_cmd;
            r_result.good_data    <= ok ? dat : r_good_data;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_result    = r_result;

endmodule

// File: rtl/ir_pulse_distance_decoder.sv
// Pulse-distance IR frame receiver. Each input transfer carries the interval, measured in ticks, between successive
// falling edges of the IR receiver; it is classified against four threshold registers
// (written through i_cfg_*; the user must write them only while the block is idle, as the
// block itself does not enforce it) as a zero bit, a one bit, a start mark or junk. A start
// mark restarts the frame; bits are collected first bit in bit 0, and after FRAME_BITS bits
// one result transfer gives the frame word, command, data, the inverted-command check and
// the last command/data that passed the check. One interval is accepted every cycle while
// s_axis_tready is high; each accepted bit or start mark is written into a four-entry queue after the
// classifier, and the last bit of a frame is popped into the output register, which raises
// m_axis_tvalid. When the result is not taken the queue fills and s_axis_tready drops.
module ir_pulse_distance_decoder import ipdd_pkg::*; #(
    parameter int FRAME_BITS = DEF_FRAME_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_addr,
    input  logic [TICK_W-1:0]      i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [TICK_W-1:0]      s_axis_tdata,   // [15:0] edge_interval
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [31:0] frame_word, [39:32] command_byte, [47:40] data_byte, [48] command_ok,
    // [56:49] good_command, [64:57] good_data, [71:65] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    t_kind   cls_kind;
    t_kind   q_kind;
    logic    q_full;
    logic    q_valid;
    logic    q_pop;
    logic    push;
    t_result result;

    ipdd_classifier u_classifier (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_interval (s_axis_tdata),
        .o_kind     (cls_kind)
    );

    assign s_axis_tready = !q_full;
    // junk changes nothing downstream, so it never enters the queue
    assign push = s_axis_tvalid && !q_full && (cls_kind != KIND_JUNK);

    ipdd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_kind  (cls_kind),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_kind  (q_kind)
    );

    ipdd_assembler #(
        .FRAME_BITS (FRAME_BITS)
    ) u_assembler (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_kind      (q_kind),
        .o_pop       (q_pop),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_result    (result)
    );

    assign m_axis_tdata = {(OUT_TDATA_W - $bits(t_result))'(0), result};

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb import ipdd_pkg::*;;

    localparam int CLK_PERIOD   = 12;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_TICKS = 8;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [1:0]             i_cfg_addr = '0;
    logic [TICK_W-1:0]      i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [TICK_W-1:0]      s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    int snd_idle_pct = 0;
    int rcv_stall_pct = 0;
    int frame_items = 0;
    int unsigned cycles = 0;

    // Tracks decoder state and holds the frames it should emit, oldest first.
    class ir_frame_tracker;
        logic [TICK_W-1:0]    zero_low_r, zero_one_r, one_start_r, start_high_r;
        logic [WORD_BITS-1:0] word;
        int unsigned          bits_taken;
        bit                   receiving;
        logic [7:0]           good_cmd, good_dat;
        t_result              pending[$];
        int                   mismatches;

        function new();
            zero_low_r   = ZERO_LOW_RST;
            zero_one_r   = ZERO_ONE_SPLIT_RST;
            one_start_r  = ONE_START_SPLIT_RST;
            start_high_r = START_HIGH_RST;
            word         = '0;
            bits_taken   = 0;
            receiving    = 1'b0;
            good_cmd     = '0;
            good_dat     = '0;
            mismatches   = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [TICK_W-1:0] v);
            case (idx)
                REG_ZERO_LOW:        zero_low_r   = v;
                REG_ZERO_ONE_SPLIT:  zero_one_r   = v;
                REG_ONE_START_SPLIT: one_start_r  = v;
                REG_START_HIGH:      start_high_r = v;
                default: ;
            endcase
        endfunction

        // strict bounds; later tests win, so start beats one beats zero
        function t_kind classify(logic [TICK_W-1:0] t);
            t_kind k;
            k = KIND_JUNK;
            if (t > zero_low_r && t < zero_one_r) k = KIND_ZERO;
            if (t > zero_one_r && t < one_start_r) k = KIND_ONE;
            if (t > one_start_r && t < start_high_r) k = KIND_START;
            return k;
        endfunction

        function void take_interval(logic [TICK_W-1:0] t);
            t_kind   k;
            t_result r;
            k = classify(t);
            if (k == KIND_START) begin
                word       = '0;
                bits_taken = 0;
                receiving  = 1'b1;
                return;
            end
            if (k == KIND_JUNK || !receiving) return;
            if (bits_taken < WORD_BITS) word[bits_taken] = (k == KIND_ONE);
            bits_taken++;
            if (bits_taken < DEF_FRAME_BITS) return;
            receiving        = 1'b0;
            bits_taken       = 0;
            r.frame_word     = word;
            r.command_byte   = word[31:24];
            r.data_byte      = word[15:8];
            r.command_ok     = (word[23:16] == ~word[31:24]);
            if (r.command_ok) begin
                good_cmd = word[31:24];
                good_dat = word[15:8];
            end
            r.good_command   = good_cmd;
            r.good_data      = good_dat;
            pending.push_back(r);
        endfunction

        task report_mismatch(string msg);
            $display("ERROR @%0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task match_frame(logic [OUT_TDATA_W-1:0] beat);
            t_result got, want;
            got = beat[$bits(t_result)-1:0];
            if (pending.size() == 0) begin
                report_mismatch($sformatf("frame %h with none expected", got.frame_word));
                return;
            end
            want = pending.pop_front();
            if (got.frame_word !== want.frame_word)
                report_mismatch($sformatf("frame_word %h, want %h",
                                          got.frame_word, want.frame_word));
            if (got.command_byte !== want.command_byte)
                report_mismatch($sformatf("command_byte %h, want %h",
                                          got.command_byte, want.command_byte));
            if (got.data_byte !== want.data_byte)
                report_mismatch($sformatf("data_byte %h, want %h",
                                          got.data_byte, want.data_byte));
            if (got.command_ok !== want.command_ok)
                report_mismatch($sformatf("command_ok %b, want %b",
                                          got.command_ok, want.command_ok));
            if (got.good_command !== want.good_command)
                report_mismatch($sformatf("good_command %h, want %h",
                                          got.good_command, want.good_command));
            if (got.good_data !== want.good_data)
                report_mismatch($sformatf("good_data %h, want %h",
                                          got.good_data, want.good_data));
        endtask
    endclass

    ir_frame_tracker frames = new();

    ir_pulse_distance_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) frames.match_frame(m_axis_tdata);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    // Draws an interval that lands in the wanted class under the current thresholds.
    function automatic logic [TICK_W-1:0] pick_interval(t_kind want);
        int          lo, hi;
        logic [TICK_W-1:0] v;
        v = TICK_W'($urandom_range(65535));
        if (want == KIND_JUNK) begin
            repeat (20) begin
                case ($urandom_range(3))
                    0: v = TICK_W'($urandom_range(65535));
                    1: case ($urandom_range(3))
                           0: v = frames.zero_low_r;
                           1: v = frames.zero_one_r;
                           2: v = frames.one_start_r;
                           default: v = frames.start_high_r;
                       endcase
                    2: v = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                    default: v = TICK_W'($urandom_range(65535));
                endcase
                if (frames.classify(v) == KIND_JUNK) return v;
            end
            return v;
        end
        case (want)
            KIND_ZERO: begin
                lo = int'(frames.zero_low_r);
                hi = int'(frames.zero_one_r);
            end
            KIND_ONE: begin
                lo = int'(frames.zero_one_r);
                hi = int'(frames.one_start_r);
            end
            default: begin
                lo = int'(frames.one_start_r);
                hi = int'(frames.start_high_r);
            end
        endcase
        if (hi - lo < 2) return v;
        repeat (20) begin
            case ($urandom_range(3))
                0: v = TICK_W'(lo + 1);
                1: v = TICK_W'(hi - 1);
                default: v = TICK_W'($urandom_range(hi - 1, lo + 1));
            endcase
            if (frames.classify(v) == want) return v;
        end
        return v;
    endfunction

    task automatic send_interval(input logic [TICK_W-1:0] t);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= t;
        do @(posedge i_clk); while (!s_axis_tready);
        frames.take_interval(t);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [TICK_W-1:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        frames.set_reg(idx, v);
    endtask

    task automatic program_thresholds(input logic [TICK_W-1:0] zl, zos, oss, sh);
        write_reg(REG_ZERO_LOW, zl);
        write_reg(REG_ZERO_ONE_SPLIT, zos);
        write_reg(REG_ONE_START_SPLIT, oss);
        write_reg(REG_START_HIGH, sh);
        i_cfg_we <= 1'b0;
    endtask

    // Sender holds off until every frame is out, then lets the pipeline empty.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (frames.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    // start mark, then bits LSB first; stop_at below 32 leaves the frame hanging
    task automatic send_frame(input logic [WORD_BITS-1:0] w, input int stop_at);
        send_interval(pick_interval(KIND_START));
        frame_items++;
        for (int i = 0; i < stop_at; i++) begin
            if ($urandom_range(9) == 0) send_interval(pick_interval(KIND_JUNK));
            send_interval(pick_interval(w[i] ? KIND_ONE : KIND_ZERO));
            frame_items++;
        end
    endtask

    task automatic run_frames(input int budget);
        int               target;
        logic [WORD_BITS-1:0] w;
        target = frame_items + budget;
        while (frame_items < target) begin
            if ($urandom_range(4) == 0) begin
                repeat ($urandom_range(3, 1)) begin
                    case ($urandom_range(2))
                        0: send_interval(pick_interval(KIND_ZERO));
                        1: send_interval(pick_interval(KIND_ONE));
                        default: send_interval(pick_interval(KIND_JUNK));
                    endcase
                end
            end
            w = $urandom;
            if ($urandom_range(1)) w[23:16] = ~w[31:24];
            send_frame(w, ($urandom_range(19) == 0) ? $urandom_range(31) : 32);
        end
    endtask

    task automatic send_list(input logic [TICK_W-1:0] vals[$]);
        foreach (vals[i]) send_interval(vals[i]);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset thresholds: bounds are exclusive, bits ignored while idle,
        // junk inside a frame, start mark dropping a partial frame
        send_list('{16'd0, 16'hFFFF, 16'd100, 16'd101, 16'd349, 16'd350, 16'd351,
                    16'd499, 16'd500, 16'd1500, 16'd501, 16'd101, 16'd499, 16'd1500,
                    16'd349, 16'd351, 16'd0, 16'd1499, 16'd499, 16'd101});
        run_frames(100);
        settle();
        run_frames(100);

        settle();
        program_thresholds(16'd0, 16'd30000, 16'd40000, 16'hFFFF);
        snd_idle_pct = 79;
        run_frames(200);

        settle();
        program_thresholds(16'd2000, 16'd2100, 16'd2200, 16'd2300);
        snd_idle_pct  = 0;
        rcv_stall_pct = 79;
        run_frames(200);

        // start range overlaps zero range: start wins; one range is empty
        settle();
        program_thresholds(16'd100, 16'd400, 16'd300, 16'd1000);
        snd_idle_pct  = 11;
        rcv_stall_pct = 11;
        send_list('{16'd200, 16'd350, 16'd200, 16'd250, 16'd301, 16'd399, 16'd400,
                    16'd1000, 16'd999, 16'd101, 16'd300, 16'd299});

        // every class empty
        settle();
        program_thresholds(16'd0, 16'd0, 16'd0, 16'd0);
        send_list('{16'd0, 16'd1, 16'd2, 16'hFFFF, 16'h5555, 16'hAAAA});
        settle();
        program_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_list('{16'hFFFF, 16'hFFFE, 16'd0, 16'd1, 16'h8000});

        // one value per class
        settle();
        program_thresholds(16'd10, 16'd12, 16'd14, 16'd16);
        run_frames(160);

        settle();
        program_thresholds(ZERO_LOW_RST, ZERO_ONE_SPLIT_RST, ONE_START_SPLIT_RST,
                           START_HIGH_RST);
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        run_frames(60);
        snd_idle_pct  = 11;
        rcv_stall_pct = 79;
        run_frames(60);

        settle();
        if (frames.mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
